FILE: src/pts_pkg.sv
// Shared types and constants of the priority task scheduler.
package pts_pkg;

	localparam int ID_W     = 5;
	localparam int OP_W     = 4;
	localparam int PRIO_W   = 8;
	localparam int FIELD_W  = 32;
	localparam int STAMP_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_SET_PRIO   = 4'd0;
	localparam logic [OP_W-1:0] OP_MAKE_READY = 4'd1;
	localparam logic [OP_W-1:0] OP_SLEEP      = 4'd2;
	localparam logic [OP_W-1:0] OP_SUSPEND    = 4'd3;
	localparam logic [OP_W-1:0] OP_RESUME     = 4'd4;
	localparam logic [OP_W-1:0] OP_WAKE       = 4'd5;
	localparam logic [OP_W-1:0] OP_TICK       = 4'd6;
	localparam logic [OP_W-1:0] OP_PREEMPT    = 4'd7;
	localparam logic [OP_W-1:0] OP_SWITCH     = 4'd8;

	localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STS_IGNORED  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NO_READY = 2'd2;

	typedef enum logic [1:0] {
		TS_SUSPEND,
		TS_READY,
		TS_SLEEP,
		TS_RUNNING
	} task_st_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_PRE,
		S_ACT,
		S_TICK_RT,
		S_TICK_SCAN,
		S_WAKE_CHK,
		S_WAKE_SCAN,
		S_WAKE_APPLY,
		S_SRCH_FIN,
		S_OUT
	} seq_st_t;

endpackage

FILE: src/pts_cmd_if.sv
// Command channel of the priority task scheduler.
interface pts_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [pts_pkg::OP_W-1:0]          operation;
	logic [pts_pkg::ID_W-1:0]          task_id;
	logic signed [pts_pkg::PRIO_W-1:0] priority_req;
	logic [pts_pkg::FIELD_W-1:0]       timeout;
	logic [pts_pkg::FIELD_W-1:0]       elapsed;

	modport source (output valid, operation, task_id, priority_req, timeout, elapsed,
		input ready);
	modport sink (input valid, operation, task_id, priority_req, timeout, elapsed,
		output ready);
endinterface

FILE: src/pts_rsp_if.sv
// Result channel of the priority task scheduler.
interface pts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pts_pkg::ID_W-1:0]      running_task;
	logic                          running_valid;
	logic                          switch_request;
	logic [pts_pkg::ID_W-1:0]      ready_head;
	logic                          ready_empty;
	logic [pts_pkg::FIELD_W-1:0]   next_wakeup;
	logic [pts_pkg::FIELD_W-1:0]   running_time;
	logic [pts_pkg::STATUS_W-1:0]  status;

	modport source (output valid, running_task, running_valid, switch_request, ready_head,
		ready_empty, next_wakeup, running_time, status, input ready);
	modport sink (input valid, running_task, running_valid, switch_request, ready_head,
		ready_empty, next_wakeup, running_time, status, output ready);
endinterface

FILE: src/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/priority_task_scheduler.sv
// Top level of the priority task scheduler: task table, sequencer and result register.
//
// Commands arrive on the cmd channel, one transaction per operation, and each
// produces exactly one transaction on the rsp channel. The block takes a new
// command only while its sequencer is idle.
// Every command ends with a walk over the task table that finds the ready head,
// one task entry per cycle through the table memories. Preempt and switch walk
// the table once more before they act. A tick that expires the earliest sleeper
// walks the table to age all sleepers, and then once more for each expired task
// to wake them in sleep order.
// After reset all tasks are suspended at priority zero, no task runs, and no
// wakeup is pending. Priorities and run times that were never written read as
// zero through a valid bit per entry, so no clearing pass is needed.
// The result sits in an output register; while the receiver stalls, the block
// still takes the next command and works on it, and holds its own result back
// until the register has been emptied.
module priority_task_scheduler #(
	parameter int TASK_COUNT = 32,
	parameter int TIME_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	pts_cmd_if.sink      cmd,
	pts_rsp_if.source    rsp
);
	import pts_pkg::*;

	localparam int IDX_W = $clog2(TASK_COUNT);
	localparam int CNT_W = $clog2(TASK_COUNT + 1);
	localparam logic [CNT_W-1:0] CNT_N = CNT_W'(TASK_COUNT);
	localparam logic [TIME_WIDTH-1:0] TM = '1;

	seq_st_t seq_q, seq_d;
	task_st_t st_q [TASK_COUNT];

	logic [OP_W-1:0]       op_q;
	logic [ID_W-1:0]       id_q;
	logic [PRIO_W-1:0]     pr_q;
	logic [TIME_WIDTH-1:0] tmo_q;
	logic [TIME_WIDTH-1:0] el_q;

	logic [IDX_W-1:0]      cur_q, cur_d;
	logic                  cur_vld_q, cur_vld_d;
	logic [STAMP_W-1:0]    oc_q, oc_d;
	logic [TIME_WIDTH-1:0] min_q, min_d;
	logic [TIME_WIDTH-1:0] pend_q, pend_d;
	logic [TIME_WIDTH-1:0] t_q, t_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  best_vld_q, best_vld_d;
	logic [IDX_W-1:0]      best_idx_q, best_idx_d;
	logic [PRIO_W-1:0]     best_pri_q, best_pri_d;
	logic [STAMP_W-1:0]    best_age_q, best_age_d;
	logic [IDX_W-1:0]      pick_q, pick_d;
	logic [STAMP_W-1:0]    pick_age_q, pick_age_d;
	logic [TASK_COUNT-1:0] exp_q, exp_d;
	logic [STATUS_W-1:0]   status_q, status_d;
	logic                  sw_q, sw_d;
	logic [TASK_COUNT-1:0] pri_vld_q;
	logic [TASK_COUNT-1:0] rt_vld_q;
	logic [IDX_W-1:0]      rd_addr_q;
	logic                  rsp_vld_q, rsp_vld_d;

	logic                  accept;
	logic                  load_out;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      wr_addr;
	logic [IDX_W-1:0]      id_x;
	logic                  idok;
	logic                  pri_we, rs_we, ss_we, tmo_we, rt_we;
	logic [TIME_WIDTH-1:0] tmo_wd, rt_wd;
	logic                  st_a_en, st_b_en;
	logic [IDX_W-1:0]      st_a_idx, st_b_idx;
	task_st_t              st_a_val, st_b_val;

	logic [PRIO_W-1:0]     pri_rdata, pri_rd;
	logic [STAMP_W-1:0]    rs_rdata, ss_rdata;
	logic [TIME_WIDTH-1:0] tmo_rdata, rt_rdata, rt_rd;
	logic [STAMP_W-1:0]    age;
	logic [TIME_WIDTH-1:0] tmo_left;
	logic                  first, last, better;

	pts_ram #(.WIDTH(PRIO_W), .DEPTH(TASK_COUNT)) u_pri_ram (
		.clk(clk), .we(pri_we), .waddr(wr_addr), .wdata(pr_q),
		.raddr(rd_addr), .rdata(pri_rdata)
	);
	pts_ram #(.WIDTH(STAMP_W), .DEPTH(TASK_COUNT)) u_rstamp_ram (
		.clk(clk), .we(rs_we), .waddr(wr_addr), .wdata(oc_q),
		.raddr(rd_addr), .rdata(rs_rdata)
	);
	pts_ram #(.WIDTH(STAMP_W), .DEPTH(TASK_COUNT)) u_sstamp_ram (
		.clk(clk), .we(ss_we), .waddr(wr_addr), .wdata(oc_q),
		.raddr(rd_addr), .rdata(ss_rdata)
	);
	pts_ram #(.WIDTH(TIME_WIDTH), .DEPTH(TASK_COUNT)) u_tmo_ram (
		.clk(clk), .we(tmo_we), .waddr(wr_addr), .wdata(tmo_wd),
		.raddr(rd_addr), .rdata(tmo_rdata)
	);
	pts_ram #(.WIDTH(TIME_WIDTH), .DEPTH(TASK_COUNT)) u_rt_ram (
		.clk(clk), .we(rt_we), .waddr(wr_addr), .wdata(rt_wd),
		.raddr(rd_addr), .rdata(rt_rdata)
	);

	assign cmd.ready = (seq_q == S_IDLE);
	assign accept    = cmd.valid && (seq_q == S_IDLE);
	assign id_x      = IDX_W'(id_q);
	assign idok      = {{(32-ID_W){1'b0}}, id_q} < 32'(TASK_COUNT);
	assign pri_rd    = pri_vld_q[rd_addr_q] ? pri_rdata : '0;
	assign rt_rd     = rt_vld_q[rd_addr_q] ? rt_rdata : '0;
	assign first     = (cnt_q == CNT_W'(1));
	assign last      = (cnt_q == CNT_N);

	always_comb begin
		seq_d      = seq_q;
		cur_d      = cur_q;
		cur_vld_d  = cur_vld_q;
		oc_d       = oc_q;
		min_d      = min_q;
		pend_d     = pend_q;
		t_d        = t_q;
		cnt_d      = cnt_q;
		best_vld_d = best_vld_q;
		best_idx_d = best_idx_q;
		best_pri_d = best_pri_q;
		best_age_d = best_age_q;
		pick_d     = pick_q;
		pick_age_d = pick_age_q;
		exp_d      = exp_q;
		status_d   = status_q;
		sw_d       = sw_q;
		rsp_vld_d  = rsp_vld_q && !rsp.ready;
		load_out   = 1'b0;
		rd_addr    = cur_q;
		wr_addr    = id_x;
		pri_we     = 1'b0;
		rs_we      = 1'b0;
		ss_we      = 1'b0;
		tmo_we     = 1'b0;
		tmo_wd     = tmo_q;
		rt_we      = 1'b0;
		rt_wd      = rt_rd + el_q;
		st_a_en    = 1'b0;
		st_a_idx   = id_x;
		st_a_val   = TS_READY;
		st_b_en    = 1'b0;
		st_b_idx   = best_idx_q;
		st_b_val   = TS_RUNNING;
		age        = oc_q - rs_rdata;
		tmo_left   = tmo_rdata - t_q;
		better     = 1'b0;

		unique case (seq_q)
			S_IDLE: begin
				if (cmd.valid) begin
					seq_d    = S_DISPATCH;
					status_d = STS_DONE;
					sw_d     = 1'b0;
				end
			end
			S_DISPATCH: begin
				seq_d = S_SRCH_FIN;
				cnt_d = '0;
				if (op_q <= OP_WAKE && !idok) begin
					status_d = STS_IGNORED;
				end else begin
					unique case (op_q)
						OP_SET_PRIO: begin
							pri_we = 1'b1;
							if (st_q[id_x] == TS_READY) begin
								rs_we = 1'b1;
								oc_d  = oc_q + 1'b1;
							end
						end
						OP_MAKE_READY, OP_WAKE: begin
							st_a_en = 1'b1;
							rs_we   = 1'b1;
							oc_d    = oc_q + 1'b1;
						end
						OP_SLEEP: begin
							st_a_en  = 1'b1;
							st_a_val = TS_SLEEP;
							tmo_we   = 1'b1;
							ss_we    = 1'b1;
							oc_d     = oc_q + 1'b1;
							if (tmo_q < min_q) begin
								min_d = tmo_q;
							end
						end
						OP_SUSPEND: begin
							st_a_en  = 1'b1;
							st_a_val = TS_SUSPEND;
						end
						OP_RESUME: begin
							if (st_q[id_x] == TS_SUSPEND) begin
								st_a_en = 1'b1;
								rs_we   = 1'b1;
								oc_d    = oc_q + 1'b1;
							end else begin
								status_d = STS_IGNORED;
							end
						end
						OP_TICK: begin
							seq_d = S_TICK_RT;
						end
						OP_PREEMPT, OP_SWITCH: begin
							seq_d = S_SRCH_PRE;
						end
						default: begin
							status_d = STS_IGNORED;
						end
					endcase
				end
			end
			S_SRCH_PRE, S_SRCH_FIN: begin
				if (!last) begin
					rd_addr = cnt_q[IDX_W-1:0];
				end
				if (cnt_q != '0) begin
					better = (st_q[rd_addr_q] == TS_READY) && (first || !best_vld_q ||
						($signed(pri_rd) > $signed(best_pri_q)) ||
						(pri_rd == best_pri_q && age > best_age_q));
					if (better) begin
						best_vld_d = 1'b1;
						best_idx_d = rd_addr_q;
						best_pri_d = pri_rd;
						best_age_d = age;
					end else if (first) begin
						best_vld_d = 1'b0;
					end
				end
				if (last) begin
					cnt_d = '0;
					seq_d = (seq_q == S_SRCH_PRE) ? S_ACT : S_OUT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_ACT: begin
				seq_d = S_SRCH_FIN;
				if (op_q == OP_SWITCH) begin
					if (!best_vld_q) begin
						status_d = STS_NO_READY;
					end else begin
						st_b_en   = 1'b1;
						sw_d      = !cur_vld_q || (cur_q != best_idx_q);
						cur_d     = best_idx_q;
						cur_vld_d = 1'b1;
					end
				end else if (cur_vld_q && st_q[cur_q] == TS_RUNNING && best_vld_q &&
					($signed(best_pri_q) >= $signed(pri_rd))) begin
					st_a_en   = 1'b1;
					st_a_idx  = cur_q;
					wr_addr   = cur_q;
					rs_we     = 1'b1;
					oc_d      = oc_q + 1'b1;
					st_b_en   = 1'b1;
					sw_d      = !cur_vld_q || (cur_q != best_idx_q);
					cur_d     = best_idx_q;
					cur_vld_d = 1'b1;
				end
			end
			S_TICK_RT: begin
				if (cur_vld_q) begin
					rt_we   = 1'b1;
					wr_addr = cur_q;
				end
				if (min_q > el_q) begin
					min_d = min_q - el_q;
					pend_d = pend_q + el_q;
					seq_d = S_SRCH_FIN;
				end else begin
					t_d    = (el_q > TM - pend_q) ? TM : el_q + pend_q;
					pend_d = '0;
					min_d  = TM;
					exp_d  = '0;
					seq_d  = S_TICK_SCAN;
				end
			end
			S_TICK_SCAN: begin
				if (!last) begin
					rd_addr = cnt_q[IDX_W-1:0];
				end
				if (cnt_q != '0 && st_q[rd_addr_q] == TS_SLEEP) begin
					tmo_we  = 1'b1;
					wr_addr = rd_addr_q;
					if (tmo_rdata > t_q) begin
						tmo_wd = tmo_left;
						if (tmo_left < min_q) begin
							min_d = tmo_left;
						end
					end else begin
						tmo_wd = '0;
						exp_d[rd_addr_q] = 1'b1;
					end
				end
				if (last) begin
					cnt_d = '0;
					seq_d = S_WAKE_CHK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_WAKE_CHK: begin
				seq_d = (exp_q != '0) ? S_WAKE_SCAN : S_SRCH_FIN;
			end
			S_WAKE_SCAN: begin
				if (!last) begin
					rd_addr = cnt_q[IDX_W-1:0];
				end
				if (cnt_q != '0 && exp_q[rd_addr_q] &&
					(first || (oc_q - ss_rdata) > pick_age_q)) begin
					pick_d     = rd_addr_q;
					pick_age_d = oc_q - ss_rdata;
				end else if (first) begin
					pick_age_d = '0;
					pick_d     = rd_addr_q;
				end
				if (last) begin
					cnt_d = '0;
					seq_d = S_WAKE_APPLY;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_WAKE_APPLY: begin
				exp_d[pick_q] = 1'b0;
				st_a_en  = 1'b1;
				st_a_idx = pick_q;
				wr_addr  = pick_q;
				rs_we    = 1'b1;
				oc_d     = oc_q + 1'b1;
				seq_d    = S_WAKE_CHK;
			end
			S_OUT: begin
				if (!rsp_vld_q || rsp.ready) begin
					load_out  = 1'b1;
					rsp_vld_d = 1'b1;
					seq_d     = S_IDLE;
				end
			end
			default: begin
				seq_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= S_IDLE;
			cur_q      <= '0;
			cur_vld_q  <= 1'b0;
			oc_q       <= '0;
			min_q      <= TM;
			pend_q     <= '0;
			cnt_q      <= '0;
			best_vld_q <= 1'b0;
			exp_q      <= '0;
			status_q   <= STS_DONE;
			sw_q       <= 1'b0;
			pri_vld_q  <= '0;
			rt_vld_q   <= '0;
			rd_addr_q  <= '0;
			rsp_vld_q  <= 1'b0;
			for (int i = 0; i < TASK_COUNT; i++) begin
				st_q[i] <= TS_SUSPEND;
			end
		end else begin
			seq_q      <= seq_d;
			cur_q      <= cur_d;
			cur_vld_q  <= cur_vld_d;
			oc_q       <= oc_d;
			min_q      <= min_d;
			pend_q     <= pend_d;
			cnt_q      <= cnt_d;
			best_vld_q <= best_vld_d;
			exp_q      <= exp_d;
			status_q   <= status_d;
			sw_q       <= sw_d;
			rd_addr_q  <= rd_addr;
			rsp_vld_q  <= rsp_vld_d;
			if (pri_we) begin
				pri_vld_q[wr_addr] <= 1'b1;
			end
			if (rt_we) begin
				rt_vld_q[wr_addr] <= 1'b1;
			end
			if (st_a_en) begin
				st_q[st_a_idx] <= st_a_val;
			end
			if (st_b_en) begin
				st_q[st_b_idx] <= st_b_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		t_q        <= t_d;
		best_idx_q <= best_idx_d;
		best_pri_q <= best_pri_d;
		best_age_q <= best_age_d;
		pick_q     <= pick_d;
		pick_age_q <= pick_age_d;
		if (accept) begin
			op_q  <= cmd.operation;
			id_q  <= cmd.task_id;
			pr_q  <= cmd.priority_req;
			tmo_q <= TIME_WIDTH'(cmd.timeout);
			el_q  <= TIME_WIDTH'(cmd.elapsed);
		end
		if (load_out) begin
			rsp.running_task   <= ID_W'(cur_q);
			rsp.running_valid  <= cur_vld_q && (st_q[cur_q] == TS_RUNNING);
			rsp.switch_request <= sw_q;
			rsp.ready_head     <= best_vld_q ? ID_W'(best_idx_q) : '0;
			rsp.ready_empty    <= !best_vld_q;
			rsp.next_wakeup    <= FIELD_W'(min_q);
			rsp.running_time   <= cur_vld_q ? FIELD_W'(rt_rd) : '0;
			rsp.status         <= status_q;
		end
	end

	assign rsp.valid = rsp_vld_q;
endmodule
